@@ src/cleb_pkg.sv @@
// Shared types and codes of the cursor line edit buffer.
package cleb_pkg;

    // Request codes as they arrive on the input stream
    localparam logic [2:0] REQ_LEFT   = 3'd0;
    localparam logic [2:0] REQ_RIGHT  = 3'd1;
    localparam logic [2:0] REQ_BKSP   = 3'd2;
    localparam logic [2:0] REQ_INSERT = 3'd3;
    localparam logic [2:0] REQ_DUMP   = 3'd4;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_LEFT,
        CMD_RIGHT,
        CMD_BKSP,
        CMD_INSERT,
        CMD_DUMP,
        CMD_NOP
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] ch;
    } t_cmd_item;

    typedef enum logic [1:0] {
        KIND_ACK,
        KIND_CHAR,
        KIND_EMPTY
    } t_kind;

    typedef enum logic [1:0] {
        STAT_DONE,
        STAT_BOUNDARY,
        STAT_FULL
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE_L,
        ST_MOVE_R,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } t_state;

endpackage

@@ src/cleb_front.sv @@
// Input stage: accept requests, decode them to commands, hand them to the queue.
module cleb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_req_type,
    input  logic [7:0]           i_char_in,
    output logic                 o_push,
    input  logic                 i_push_ready,
    output cleb_pkg::t_cmd_item  o_item
);

    logic                r_valid;
    cleb_pkg::t_cmd_item r_item;
    cleb_pkg::t_cmd      cmd;

    always_comb begin
        case (i_req_type)
            cleb_pkg::REQ_LEFT:   cmd = cleb_pkg::CMD_LEFT;
            cleb_pkg::REQ_RIGHT:  cmd = cleb_pkg::CMD_RIGHT;
            cleb_pkg::REQ_BKSP:   cmd = cleb_pkg::CMD_BKSP;
            cleb_pkg::REQ_INSERT: cmd = cleb_pkg::CMD_INSERT;
            cleb_pkg::REQ_DUMP:   cmd = cleb_pkg::CMD_DUMP;
            default:              cmd = cleb_pkg::CMD_NOP;
        endcase
    end

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.cmd <= cmd;
            r_item.ch  <= i_char_in;
        end
    end

endmodule

@@ src/cleb_queue.sv @@
// Short command queue between the decode stage and the edit engine.
module cleb_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_push_ready,
    input  cleb_pkg::t_cmd_item  i_item,
    output logic                 o_valid,
    input  logic                 i_pop,
    output cleb_pkg::t_cmd_item  o_item
);

    localparam int PW = $clog2(cleb_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(cleb_pkg::QUEUE_DEPTH + 1);

    cleb_pkg::t_cmd_item r_mem [cleb_pkg::QUEUE_DEPTH];
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_rp;
    logic [NW-1:0]       r_cnt;
    logic                push_ok;
    logic                pop_ok;

    assign o_push_ready = (r_cnt != NW'(cleb_pkg::QUEUE_DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_item       = r_mem[r_rp];
    assign push_ok      = i_push && o_push_ready;
    assign pop_ok       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PW'(cleb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PW'(cleb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ src/cleb_back.sv @@
// Edit engine: two character stacks, their counts, dump sequencer and result register.
module cleb_back #(
    parameter int TEXT_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  cleb_pkg::t_cmd_item  i_q_item,
    output logic                 o_q_pop,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    output cleb_pkg::t_kind      o_m_kind,
    output logic [7:0]           o_m_char,
    output cleb_pkg::t_status    o_m_status,
    output logic                 o_m_last
);

    localparam int CW = $clog2(TEXT_DEPTH + 1);
    localparam int AW = $clog2(TEXT_DEPTH);

    cleb_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_lcnt, n_lcnt;
    logic [CW-1:0]     r_rcnt, n_rcnt;
    logic [AW-1:0]     r_pos, n_pos;
    logic              r_on_left, n_on_left;
    logic [CW-1:0]     r_rem, n_rem;
    logic [7:0]        r_lq, r_rq;
    logic [7:0]        left_mem  [TEXT_DEPTH];
    logic [7:0]        right_mem [TEXT_DEPTH];

    logic              r_ovalid;
    cleb_pkg::t_kind   r_okind, n_okind;
    logic [7:0]        r_ochar, n_ochar;
    cleb_pkg::t_status r_ostatus, n_ostatus;
    logic              r_olast, n_olast;
    logic              out_load;

    logic              out_free;
    logic [CW-1:0]     lc_m1, rc_m1;
    logic [CW:0]       total;
    logic              can_left, can_right, is_full;

    logic              l_we, r_we;
    logic [AW-1:0]     l_waddr, r_waddr, l_raddr, r_raddr;
    logic [7:0]        l_wdata, r_wdata;

    assign out_free  = !r_ovalid || i_m_ready;
    assign lc_m1     = r_lcnt - 1'b1;
    assign rc_m1     = r_rcnt - 1'b1;
    assign total     = {1'b0, r_lcnt} + {1'b0, r_rcnt};
    assign can_left  = (r_lcnt != '0) && (r_rcnt < CW'(TEXT_DEPTH));
    assign can_right = (r_rcnt != '0) && (r_lcnt < CW'(TEXT_DEPTH));
    assign is_full   = (total >= (CW+1)'(TEXT_DEPTH));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cleb_pkg::ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    case (i_q_item.cmd)
                        cleb_pkg::CMD_LEFT:  if (can_left)  n_state = cleb_pkg::ST_MOVE_L;
                        cleb_pkg::CMD_RIGHT: if (can_right) n_state = cleb_pkg::ST_MOVE_R;
                        cleb_pkg::CMD_DUMP:  if (total != '0) n_state = cleb_pkg::ST_DUMP_RD;
                        default:             n_state = cleb_pkg::ST_IDLE;
                    endcase
                end
            end
            cleb_pkg::ST_MOVE_L:  n_state = cleb_pkg::ST_IDLE;
            cleb_pkg::ST_MOVE_R:  n_state = cleb_pkg::ST_IDLE;
            cleb_pkg::ST_DUMP_RD: n_state = cleb_pkg::ST_DUMP_OUT;
            cleb_pkg::ST_DUMP_OUT: begin
                if (out_free) begin
                    n_state = (r_rem == CW'(1)) ? cleb_pkg::ST_IDLE : cleb_pkg::ST_DUMP_RD;
                end
            end
            default: n_state = cleb_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        o_q_pop   = 1'b0;
        n_lcnt    = r_lcnt;
        n_rcnt    = r_rcnt;
        n_pos     = r_pos;
        n_on_left = r_on_left;
        n_rem     = r_rem;
        out_load  = 1'b0;
        n_okind   = cleb_pkg::KIND_ACK;
        n_ochar   = 8'd0;
        n_ostatus = cleb_pkg::STAT_DONE;
        n_olast   = 1'b1;
        l_we      = 1'b0;
        r_we      = 1'b0;
        l_waddr   = r_lcnt[AW-1:0];
        r_waddr   = r_rcnt[AW-1:0];
        l_wdata   = i_q_item.ch;
        r_wdata   = r_lq;
        l_raddr   = lc_m1[AW-1:0];
        r_raddr   = rc_m1[AW-1:0];
        case (r_state)
            cleb_pkg::ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop  = 1'b1;
                    out_load = 1'b1;
                    case (i_q_item.cmd)
                        cleb_pkg::CMD_LEFT: begin
                            if (can_left) n_lcnt = lc_m1;
                            else          n_ostatus = cleb_pkg::STAT_BOUNDARY;
                        end
                        cleb_pkg::CMD_RIGHT: begin
                            if (can_right) n_rcnt = rc_m1;
                            else           n_ostatus = cleb_pkg::STAT_BOUNDARY;
                        end
                        cleb_pkg::CMD_BKSP: begin
                            if (r_lcnt != '0) n_lcnt = lc_m1;
                            else              n_ostatus = cleb_pkg::STAT_BOUNDARY;
                        end
                        cleb_pkg::CMD_INSERT: begin
                            if (is_full) begin
                                n_ostatus = cleb_pkg::STAT_FULL;
                            end else begin
                                l_we   = 1'b1;
                                n_lcnt = r_lcnt + 1'b1;
                            end
                        end
                        cleb_pkg::CMD_DUMP: begin
                            if (total == '0) begin
                                n_okind = cleb_pkg::KIND_EMPTY;
                            end else begin
                                out_load  = 1'b0;
                                n_pos     = (r_lcnt != '0) ? '0 : rc_m1[AW-1:0];
                                n_on_left = (r_lcnt != '0);
                                n_rem     = total[CW-1:0];
                            end
                        end
                        default: n_ostatus = cleb_pkg::STAT_DONE;
                    endcase
                end
            end
            cleb_pkg::ST_MOVE_L: begin
                // read of the left top landed last cycle; push it on the right
                r_we   = 1'b1;
                n_rcnt = r_rcnt + 1'b1;
            end
            cleb_pkg::ST_MOVE_R: begin
                l_we    = 1'b1;
                l_wdata = r_rq;
                n_lcnt  = r_lcnt + 1'b1;
            end
            cleb_pkg::ST_DUMP_RD: begin
                l_raddr = r_pos;
                r_raddr = r_pos;
            end
            cleb_pkg::ST_DUMP_OUT: begin
                // hold the read address so a stalled result keeps its character
                l_raddr = r_pos;
                r_raddr = r_pos;
                if (out_free) begin
                    out_load = 1'b1;
                    n_okind  = cleb_pkg::KIND_CHAR;
                    n_ochar  = r_on_left ? r_lq : r_rq;
                    n_olast  = (r_rem == CW'(1));
                    n_rem    = r_rem - 1'b1;
                    if (r_on_left) begin
                        if (r_pos == lc_m1[AW-1:0]) begin
                            n_on_left = 1'b0;
                            n_pos     = rc_m1[AW-1:0];
                        end else begin
                            n_pos = r_pos + 1'b1;
                        end
                    end else begin
                        n_pos = r_pos - 1'b1;
                    end
                    if (r_rem == CW'(1)) begin
                        n_lcnt = '0;
                        n_rcnt = '0;
                    end
                end
            end
            default: o_q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cleb_pkg::ST_IDLE;
            r_lcnt   <= '0;
            r_rcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lcnt  <= n_lcnt;
            r_rcnt  <= n_rcnt;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_on_left <= n_on_left;
        r_rem     <= n_rem;
        if (out_load) begin
            r_okind   <= n_okind;
            r_ochar   <= n_ochar;
            r_ostatus <= n_ostatus;
            r_olast   <= n_olast;
        end
    end

    // Stack memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (l_we) begin
            left_mem[l_waddr] <= l_wdata;
        end
        r_lq <= left_mem[l_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            right_mem[r_waddr] <= r_wdata;
        end
        r_rq <= right_mem[r_raddr];
    end

    assign o_m_valid  = r_ovalid;
    assign o_m_kind   = r_okind;
    assign o_m_char   = r_ochar;
    assign o_m_status = r_ostatus;
    assign o_m_last   = r_olast;

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        total <= (CW+1)'(TEXT_DEPTH))
        else $error("text holds more characters than the buffer depth");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == cleb_pkg::ST_IDLE))
        else $error("command taken while engine busy");

    a_move_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cleb_pkg::ST_MOVE_L || r_state == cleb_pkg::ST_MOVE_R)
        |=> (r_state == cleb_pkg::ST_IDLE))
        else $error("cursor move did not finish in one cycle");

    a_dump_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cleb_pkg::ST_DUMP_OUT && out_free && r_rem == CW'(1))
        |=> (r_lcnt == '0 && r_rcnt == '0 && r_olast))
        else $error("dump end did not empty the buffer");

    a_char_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_okind != cleb_pkg::KIND_ACK) |-> (r_ostatus == cleb_pkg::STAT_DONE))
        else $error("dump result carries a nonzero status");

endmodule

@@ src/cursor_line_edit_buffer_unit.sv @@
// Top level of the cursor line edit buffer: decode stage, command queue and edit engine.
//
// A line of up to TEXT_DEPTH characters with a cursor, kept as two stacks (text left
// of the cursor, text right of it). Each request on the slave stream is one transfer:
// tuser carries the request code (0 cursor left, 1 cursor right, 2 backspace,
// 3 insert, 4 dump, other codes are acknowledged and do nothing) and tdata the
// character for insert. Every edit gives one acknowledge transfer on the master
// stream with a status (done, ignored at a boundary, ignored because the buffer is
// full); a dump streams the text in reading order, one transfer per character with
// tlast on the final one, or a single "empty" transfer, and leaves the buffer empty.
// Flow: a request passes a decode register and a two-entry queue before the engine;
// the engine handles backspace, insert and no-op requests as it takes them, a cursor
// move as a stack memory read, then a write to the other stack (no write when the move
// is ignored at a boundary), and each character of a dump as a registered memory read,
// then a load of the result register; a stall on the result stream holds the engine
// until the result register is free. The queue keeps taking requests while it has
// room, also while the engine works or the result stream is stalled. No clearing pass
// is needed after reset.
module cursor_line_edit_buffer_unit #(
    parameter int TEXT_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_out, [9:8] status, [15:10] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last result of the request
);

    logic                push;
    logic                push_ready;
    cleb_pkg::t_cmd_item front_item;
    logic                q_valid;
    logic                q_pop;
    cleb_pkg::t_cmd_item q_item;
    cleb_pkg::t_kind     m_kind;
    logic [7:0]          m_char;
    cleb_pkg::t_status   m_status;

    // Decode each request transfer into an engine command
    cleb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_char_in    (s_axis_tdata),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_item       (front_item)
    );

    // Hold commands so decode and engine stall independently
    cleb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_item       (front_item),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_item       (q_item)
    );

    // Carry out edits and dumps on the two stacks
    cleb_back #(
        .TEXT_DEPTH (TEXT_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_kind   (m_kind),
        .o_m_char   (m_char),
        .o_m_status (m_status),
        .o_m_last   (m_axis_tlast)
    );

    // Pack result fields, lowest field first, pad to whole bytes
    assign m_axis_tdata = {6'd0, m_status, m_char};
    assign m_axis_tuser = m_kind;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the cursor line edit buffer: stream driver, result monitor, predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int TEXT_DEPTH = 64;
    // Request codes with no edit behind them; the block only acknowledges them
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
    localparam int RANDOM_REQS  = 380;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [2:0] req;
        logic [7:0] ch;
    } t_edit_req;

    typedef struct {
        cleb_pkg::t_kind   kind;
        logic [7:0]        ch;
        cleb_pkg::t_status status;
        logic              last;
    } t_text_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] char_in
    logic [2:0]  s_axis_tuser = 3'd0;   // [2:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [7:0] char_out, [9:8] status, [15:10] zero
    logic [1:0]  m_axis_tuser;          // [1:0] kind
    logic        m_axis_tlast;

    // Pending requests for the driver, results still owed by the block
    t_edit_req    req_queue[$];
    t_text_result owed_results[$];

    // Shadow of the two stacks
    logic [7:0] shadow_left[TEXT_DEPTH];
    logic [7:0] shadow_right[TEXT_DEPTH];
    int unsigned shadow_left_cnt = 0;
    int unsigned shadow_right_cnt = 0;

    int total_reqs = 0;
    int accepted_reqs = 0;
    int mismatch_count = 0;
    int tx_idle_pct;
    int rx_idle_pct;
    t_edit_req next_req;

    cursor_line_edit_buffer_unit #(
        .TEXT_DEPTH(TEXT_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle profile follows progress through the request list:
    // sender sparse / receiver choked, then swapped, then full rate.
    always @(*) begin
        if (accepted_reqs < total_reqs / 3) begin
            tx_idle_pct = 35;
            rx_idle_pct = 81;
        end else if (accepted_reqs < (2 * total_reqs) / 3) begin
            tx_idle_pct = 81;
            rx_idle_pct = 35;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    task automatic owe(input cleb_pkg::t_kind kind, input logic [7:0] ch,
                       input cleb_pkg::t_status status, input logic last);
        t_text_result r;
        r.kind   = kind;
        r.ch     = ch;
        r.status = status;
        r.last   = last;
        owed_results.push_back(r);
    endtask

    // Apply one accepted request to the shadow stacks and queue what it owes
    task automatic predict_edit(input logic [2:0] req, input logic [7:0] ch);
        cleb_pkg::t_status status;
        int unsigned       total;
        int unsigned       n;
        status = cleb_pkg::STAT_DONE;
        case (req)
            cleb_pkg::REQ_LEFT: begin
                if (shadow_left_cnt == 0 || shadow_right_cnt >= TEXT_DEPTH) begin
                    status = cleb_pkg::STAT_BOUNDARY;
                end else begin
                    shadow_left_cnt--;
                    shadow_right[shadow_right_cnt] = shadow_left[shadow_left_cnt];
                    shadow_right_cnt++;
                end
            end
            cleb_pkg::REQ_RIGHT: begin
                if (shadow_right_cnt == 0 || shadow_left_cnt >= TEXT_DEPTH) begin
                    status = cleb_pkg::STAT_BOUNDARY;
                end else begin
                    shadow_right_cnt--;
                    shadow_left[shadow_left_cnt] = shadow_right[shadow_right_cnt];
                    shadow_left_cnt++;
                end
            end
            cleb_pkg::REQ_BKSP: begin
                if (shadow_left_cnt == 0) status = cleb_pkg::STAT_BOUNDARY;
                else shadow_left_cnt--;
            end
            cleb_pkg::REQ_INSERT: begin
                if (shadow_left_cnt + shadow_right_cnt >= TEXT_DEPTH) begin
                    status = cleb_pkg::STAT_FULL;
                end else begin
                    shadow_left[shadow_left_cnt] = ch;
                    shadow_left_cnt++;
                end
            end
            cleb_pkg::REQ_DUMP: begin
                total = shadow_left_cnt + shadow_right_cnt;
                if (total == 0) begin
                    owe(cleb_pkg::KIND_EMPTY, 8'd0, cleb_pkg::STAT_DONE, 1'b1);
                end else begin
                    // Reading order: left stack bottom up, then right stack top down
                    n = 0;
                    for (int unsigned i = 0; i < shadow_left_cnt; i++) begin
                        n++;
                        owe(cleb_pkg::KIND_CHAR, shadow_left[i], cleb_pkg::STAT_DONE,
                            n == total);
                    end
                    for (int unsigned i = shadow_right_cnt; i > 0; i--) begin
                        n++;
                        owe(cleb_pkg::KIND_CHAR, shadow_right[i - 1], cleb_pkg::STAT_DONE,
                            n == total);
                    end
                end
                shadow_left_cnt = 0;
                shadow_right_cnt = 0;
                return;
            end
            default: ;
        endcase
        owe(cleb_pkg::KIND_ACK, 8'd0, status, 1'b1);
    endtask

    // Request driver: advance on each transfer, insert random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_edit(s_axis_tuser, s_axis_tdata);
                accepted_reqs <= accepted_reqs + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_req = req_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_req.req;
                    s_axis_tdata  <= next_req.ch;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: random stalls, check every transfer against the oldest owed result
    always @(posedge i_clk) begin
        t_text_result want;
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (owed_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected result: kind %0d tdata %h last %b",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                want = owed_results.pop_front();
                if (m_axis_tuser !== want.kind || m_axis_tdata !== {6'd0, want.status, want.ch}
                        || m_axis_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Result mismatch: kind %0d/%0d char %h/%h status %0d/%0d %s",
                                 m_axis_tuser, want.kind, m_axis_tdata[7:0], want.ch,
                                 m_axis_tdata[9:8], want.status,
                                 $sformatf("upper %h/0 last %b/%b (got/want)",
                                           m_axis_tdata[15:10], m_axis_tlast, want.last));
                end
            end
        end
    end

    function automatic void add_req(input logic [2:0] req, input logic [7:0] ch);
        t_edit_req r;
        r.req = req;
        r.ch  = ch;
        req_queue.push_back(r);
    endfunction

    // One random edit; returns 1 if it is a real edit rather than an unused code
    function automatic int add_random_edit(input bit favor_insert);
        int pick;
        pick = $urandom_range(99);
        if (favor_insert && pick < 80) pick = 0;
        if (pick < 50) add_req(cleb_pkg::REQ_INSERT, 8'($urandom));
        else if (pick < 65) add_req(cleb_pkg::REQ_LEFT, 8'($urandom));
        else if (pick < 80) add_req(cleb_pkg::REQ_RIGHT, 8'($urandom));
        else if (pick < 93) add_req(cleb_pkg::REQ_BKSP, 8'($urandom));
        else begin
            add_req(3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST)), 8'($urandom));
            return 0;
        end
        return 1;
    endfunction

    initial begin
        int counted;
        int waited;
        int edits;
        int fill_target;

        // Directed: boundaries on an empty line, extreme characters, unused codes
        add_req(cleb_pkg::REQ_DUMP,   8'hFF);
        add_req(cleb_pkg::REQ_LEFT,   8'h00);
        add_req(cleb_pkg::REQ_RIGHT,  8'hFF);
        add_req(cleb_pkg::REQ_BKSP,   8'h00);
        add_req(cleb_pkg::REQ_INSERT, 8'h00);
        add_req(cleb_pkg::REQ_INSERT, 8'hFF);
        add_req(cleb_pkg::REQ_INSERT, "L");
        add_req(cleb_pkg::REQ_LEFT,   8'h00);
        add_req(cleb_pkg::REQ_LEFT,   8'h00);
        add_req(cleb_pkg::REQ_LEFT,   8'h00);
        add_req(cleb_pkg::REQ_LEFT,   8'h00);
        add_req(cleb_pkg::REQ_BKSP,   8'hFF);
        add_req(cleb_pkg::REQ_INSERT, "D");
        add_req(cleb_pkg::REQ_RIGHT,  8'h00);
        add_req(cleb_pkg::REQ_INSERT, "B");
        add_req(cleb_pkg::REQ_RIGHT,  8'h00);
        add_req(cleb_pkg::REQ_RIGHT,  8'h00);
        add_req(cleb_pkg::REQ_RIGHT,  8'h00);
        add_req(cleb_pkg::REQ_INSERT, "P");
        add_req(REQ_UNUSED_FIRST,     8'hAA);
        add_req(3'd6,                 8'h55);
        add_req(REQ_UNUSED_LAST,      8'hFF);
        add_req(cleb_pkg::REQ_DUMP,   8'h00);
        add_req(cleb_pkg::REQ_DUMP,   8'h00);

        // Random sessions of edits closed by a dump; the first one and a few later
        // ones issue more inserts than the line can hold, mixed with backspaces and unused codes
        counted = 0;
        while (counted < RANDOM_REQS) begin
            if (counted == 0 || $urandom_range(7) == 0) begin
                fill_target = TEXT_DEPTH + $urandom_range(4, 1);
                edits = 0;
                while (edits < fill_target) begin
                    if (add_random_edit(1'b1)) counted++;
                    if (req_queue[req_queue.size() - 1].req == cleb_pkg::REQ_INSERT) edits++;
                end
            end else begin
                edits = $urandom_range(24, 2);
                for (int i = 0; i < edits; i++)
                    counted += add_random_edit(1'b0);
            end
            // Now and then probe the boundaries before the dump
            if ($urandom_range(3) == 0) begin
                add_req(cleb_pkg::REQ_LEFT, 8'($urandom));
                add_req(cleb_pkg::REQ_RIGHT, 8'($urandom));
                counted += 2;
            end
            add_req(cleb_pkg::REQ_DUMP, 8'($urandom));
            counted++;
        end
        total_reqs = req_queue.size();

        // Hold reset, then release it at a clock edge
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all requests transferred, all results seen, then a short tail
        while (req_queue.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (owed_results.size() != 0) mismatch_count += owed_results.size();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
